// ===== rtl/mmws_pkg.sv =====
package mmws_pkg;

	// fixed field widths of the sample and result words
	localparam int CH_W      = 4;
	localparam int SMP_W     = 12;
	localparam int SUM_W     = 20;
	localparam int OUT_SUM_W = 19;

endpackage

// ===== rtl/mmws_ram.sv =====
module mmws_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1664
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/multichannel_moving_window_sum_top.sv =====
// path: an accepted word passes the stage 1 register, then the result register
// throughput: one word per cycle unless out_ready stalls the result, set by the single
// read-modify-write of the window store; reset clears sums and window position at once,
// then the store, one entry per cycle, CHANNELS*WINDOW (1664 at defaults), in_ready low
module multichannel_moving_window_sum_top
	import mmws_pkg::*;
#(
	parameter int CHANNELS    = 13,
	parameter int WINDOW      = 128,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CH_W-1:0]      channel,
	input  logic [SMP_W-1:0]     sample,
	input  logic                 end_of_set,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      channel_out,
	output logic [OUT_SUM_W-1:0] window_sum
);

	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int POS_W    = $clog2(WINDOW);
	localparam int SW       = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              in_acc;
	logic              s1_adv;
	logic              in_range;
	logic [ADDR_W-1:0] addr_in;
	logic [SW-1:0]     fresh_in;

	logic              valid_s1;
	logic [CH_W-1:0]   channel_s1;
	logic [SW-1:0]     fresh_s1;
	logic              range_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              byp_s1;
	logic [SW-1:0]     byp_data_s1;

	logic [POS_W-1:0]  pos_q;
	logic [SUM_W-1:0]  sums_q [CHANNELS];
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              out_valid_q;
	logic [CH_W-1:0]   channel_out_q;
	logic [OUT_SUM_W-1:0] window_sum_q;

	logic [SW-1:0]     rdata;
	logic [SW-1:0]     stale;
	logic [SW-1:0]     diff;
	logic [SUM_W-1:0]  sum_old;
	logic [SUM_W-1:0]  sum_new;
	logic [CH_IDX_W-1:0] chi_s1;
	logic              wr_s1;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [SW-1:0]     ram_wdata;

	// handshake
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || s1_adv);
	assign in_acc   = in_valid && in_ready;

	// store address of the incoming word
	assign in_range = int'(channel) < CHANNELS;
	assign fresh_in = sample[SW-1:0];
	assign addr_in  = ADDR_W'(ADDR_W'(channel) * ADDR_W'(WINDOW)) + ADDR_W'(pos_q);

	// store write: clearing pass, else the word leaving stage 1
	assign wr_s1     = s1_adv && range_s1;
	assign ram_we    = clr_busy_q || wr_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : fresh_s1;

	mmws_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(addr_in),
		.rdata(rdata)
	);

	// stage 1 register, with bypass for a write to the same slot on the read edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			channel_s1  <= channel;
			fresh_s1    <= fresh_in;
			range_s1    <= in_range;
			addr_s1     <= addr_in;
			byp_s1      <= wr_s1 && (addr_s1 == addr_in);
			byp_data_s1 <= fresh_s1;
		end
	end

	// running sum update with clamp at zero
	assign chi_s1  = CH_IDX_W'(channel_s1);
	assign stale   = byp_s1 ? byp_data_s1 : rdata;
	assign sum_old = range_s1 ? sums_q[chi_s1] : '0;
	assign diff    = (fresh_s1 >= stale) ? (fresh_s1 - stale) : (stale - fresh_s1);

	always_comb begin
		if (fresh_s1 >= stale) begin
			sum_new = sum_old + SUM_W'(diff);
		end else if (sum_old >= SUM_W'(diff)) begin
			sum_new = sum_old - SUM_W'(diff);
		end else begin
			sum_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (wr_s1) begin
			sums_q[chi_s1] <= sum_new;
		end
	end

	// shared window position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc && end_of_set) begin
			pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	// clearing pass over the window store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			channel_out_q <= channel_s1;
			window_sum_q  <= range_s1 ? sum_new[OUT_SUM_W-1:0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_out_q;
	assign window_sum  = window_sum_q;

endmodule
